@@ hdl/lsh_pkg.sv @@
package lsh_pkg;

    // Field widths fixed by the item format
    localparam int BYTE_W      = 64;
    localparam int BIN_W       = 6;
    localparam int OUT_COUNT_W = 32;

    // Record sizes are taken in KiB units
    localparam int SIZE_SHIFT  = 10;
    localparam int QUOT_W      = BYTE_W - SIZE_SHIFT;

    typedef enum logic [0:0] {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } t_op;

endpackage

@@ hdl/lsh_bin_enc.sv @@
module lsh_bin_enc
    import lsh_pkg::*;
(
    input  logic [BYTE_W-1:0] i_byte_count,
    output logic [BIN_W-1:0]  o_bin
);

    logic [QUOT_W-1:0] quot;

    assign quot = i_byte_count[BYTE_W-1:SIZE_SHIFT];

    // floor(log2(quot)); zero and one both land in bin 0
    always_comb begin
        o_bin = '0;
        for (int k = 1; k < QUOT_W; k++) begin
            if (quot[k]) begin
                o_bin = BIN_W'(k);
            end
        end
    end

endmodule

@@ hdl/lsh_ram.sv @@
module lsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/log2_size_histogram.sv @@
// An accepted input beat goes through the stage 1 registers, then the result register, to o_valid.
// Throughput: one beat per cycle while the result channel does not stall, also on back-to-back records to the same bin.
// The read stage stalls only when it is full and the result register holds a stalled beat.
// Reset (i_rst_n low, synchronous): pipeline emptied and every bin reads as zero
// at once, through per-bin valid flags; the counter RAM itself is not swept.
module log2_size_histogram
    import lsh_pkg::*;
#(
    parameter int NUM_BINS    = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_operation,
    input  logic [BYTE_W-1:0]      i_byte_count,
    input  logic [BIN_W-1:0]       i_bin_select,
    // result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [BIN_W-1:0]       o_bin,
    output logic [OUT_COUNT_W-1:0] o_count
);

    localparam int AW = $clog2(NUM_BINS);

    // ---------------------------------------------------------------
    // Stage 0: decode the beat, pick the bin, launch the RAM read
    // ---------------------------------------------------------------
    t_op              in_op;
    logic [BIN_W-1:0] rec_bin;
    logic [BIN_W-1:0] in_addr;
    logic             in_range;
    logic             in_accept;

    assign in_op     = t_op'(i_operation);
    assign in_addr   = (in_op == OP_RECORD) ? rec_bin : i_bin_select;
    // records always hit bins 0..53; a bin at or above NUM_BINS is out of range
    assign in_range  = (32'(in_addr) < 32'(NUM_BINS));
    assign in_accept = i_valid && !o_stall;

    lsh_bin_enc u_enc (
        .i_byte_count (i_byte_count),
        .o_bin        (rec_bin)
    );

    // ---------------------------------------------------------------
    // Stage 1 registers: beat info plus the RAM read in flight
    // ---------------------------------------------------------------
    logic                   r_s1_valid;
    t_op                    r_s1_op;
    logic [BIN_W-1:0]       r_s1_addr;
    logic                   r_s1_range;
    logic                   r_s1_vbit;     // bin written since reset
    logic                   r_s1_fwd;      // bin written on the read edge
    logic [COUNT_WIDTH-1:0] r_s1_fwd_data;

    logic [NUM_BINS-1:0]    r_bin_vld;
    logic [COUNT_WIDTH-1:0] ram_rdata;

    logic                   s1_adv;
    logic                   wr_en;
    logic [COUNT_WIDTH-1:0] old_count;
    logic [COUNT_WIDTH-1:0] new_count;
    logic [63:0]            res_wide;

    logic                   r_o_valid;
    logic [BIN_W-1:0]       r_o_bin;
    logic [OUT_COUNT_W-1:0] r_o_count;

    // s1 moves on whenever the result register is free or draining
    assign s1_adv  = r_s1_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign wr_en   = s1_adv && (r_s1_op == OP_RECORD);

    lsh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_addr[AW-1:0]),
        .i_wdata (new_count),
        .i_re    (in_accept && in_range),
        .i_raddr (in_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Stage 1 logic: resolve the stored count, pick the result, saturating increment
    // ---------------------------------------------------------------
    always_comb begin
        if (r_s1_fwd) begin
            old_count = r_s1_fwd_data;
        end else if (r_s1_vbit) begin
            old_count = ram_rdata;
        end else begin
            old_count = '0;
        end
        new_count = (old_count == {COUNT_WIDTH{1'b1}}) ? old_count
                                                       : old_count + COUNT_WIDTH'(1);
        if (r_s1_op == OP_RECORD) begin
            res_wide = 64'(new_count);
        end else if (r_s1_range) begin
            res_wide = 64'(old_count);
        end else begin
            res_wide = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_bin_vld  <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (wr_en) begin
                r_bin_vld[r_s1_addr[AW-1:0]] <= 1'b1;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op       <= in_op;
            r_s1_addr     <= in_addr;
            r_s1_range    <= in_range;
            r_s1_vbit     <= in_range ? r_bin_vld[in_addr[AW-1:0]] : 1'b0;
            // write landing on the same edge as the read: RAM gives stale data
            r_s1_fwd      <= wr_en && (r_s1_addr == in_addr);
            r_s1_fwd_data <= new_count;
        end
        if (s1_adv) begin
            r_o_bin   <= r_s1_addr;
            // clamp to the 32-bit result field
            r_o_count <= (res_wide > 64'hFFFF_FFFF) ? {OUT_COUNT_W{1'b1}}
                                                    : res_wide[OUT_COUNT_W-1:0];
        end
    end

    assign o_valid = r_o_valid;
    assign o_bin   = r_o_bin;
    assign o_count = r_o_count;

endmodule
